// File: sv/mlft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mlft_pkg;

  localparam int unsigned Entries  = 256;
  localparam int unsigned IdxW     = $clog2(Entries);
  localparam int unsigned CntW     = $clog2(Entries + 1);
  localparam int unsigned MacW     = 48;
  localparam int unsigned PortW    = 8;
  localparam int unsigned GroupBit = 40;

  typedef struct packed {
    logic [MacW-1:0]  src_mac;
    logic [MacW-1:0]  dst_mac;
    logic [PortW-1:0] in_port;
  } in_word_t;

  typedef struct packed {
    logic             flood;
    logic [PortW-1:0] egress_port;
  } out_word_t;

  typedef struct packed {
    logic [MacW-1:0]  mac;
    logic [PortW-1:0] port;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage
`default_nettype wire

// File: sv/mlft_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mlft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: sv/mac_learning_forward_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Layer-2 learning forwarding table. Each input word is one frame header
// (source MAC, destination MAC, ingress port); each output word is one
// forwarding decision (flood flag, egress port). Entries live in one
// synchronous RAM and are filled in order, so slots below the fill count are
// the valid ones and no clearing pass is needed after reset. StIdle takes the
// header; StScan reads one entry per cycle through the single RAM read port,
// up to the fill count, and compares it against both source and destination,
// staying on until the last read has returned; then StDone writes back the
// learned entry, if any, and loads the result register. StDone holds while a
// previous result still waits on out_ready_i. A new header is taken while a
// result still waits.
module mac_learning_forward_table_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mlft_pkg::in_word_t in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output mlft_pkg::out_word_t     out_word_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] state_q, state_d;

  // header under work
  mlft_pkg::in_word_t hdr_q;

  // fill count and scan pointer
  logic [mlft_pkg::CntW-1:0] count_q, count_d;
  logic [mlft_pkg::CntW-1:0] cnt_q, cnt_d;

  // read in flight, and which slot it was
  logic                      pend_q, pend_d;
  logic [mlft_pkg::IdxW-1:0] pend_idx_q;

  // scan results
  logic                       src_hit_q, src_hit_d;
  logic [mlft_pkg::IdxW-1:0]  src_slot_q, src_slot_d;
  logic                       dst_hit_q, dst_hit_d;
  logic [mlft_pkg::PortW-1:0] dst_port_q, dst_port_d;

  logic                out_valid_q, out_valid_d;
  mlft_pkg::out_word_t out_word_q, out_word_d;

  // RAM side
  logic                      we;
  logic [mlft_pkg::IdxW-1:0] waddr;
  mlft_pkg::entry_t          wentry;
  mlft_pkg::entry_t          rentry;
  logic [mlft_pkg::EntryW-1:0] rdata;

  logic in_acc, issue, src_uni, dst_grp, has_room, learned, finish;

  mlft_ram #(
    .Width (mlft_pkg::EntryW),
    .Depth (mlft_pkg::Entries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wentry),
    .raddr_i (cnt_q[mlft_pkg::IdxW-1:0]),
    .rdata_o (rdata)
  );

  assign rentry = mlft_pkg::entry_t'(rdata);

  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign src_uni  = !hdr_q.src_mac[mlft_pkg::GroupBit];
  assign dst_grp  = hdr_q.dst_mac[mlft_pkg::GroupBit];
  assign has_room = (count_q < mlft_pkg::CntW'(mlft_pkg::Entries));
  // source ends up in the table (updated or inserted)
  assign learned  = src_uni && (src_hit_q || has_room);
  // result register free to take this decision
  assign finish   = (state_q == StDone) && (!out_valid_q || out_ready_i);
  assign issue    = (state_q == StScan) && (cnt_q < count_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cnt_d       = cnt_q;
    pend_d      = issue;
    src_hit_d   = src_hit_q;
    src_slot_d  = src_slot_q;
    dst_hit_d   = dst_hit_q;
    dst_port_d  = dst_port_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    we          = 1'b0;
    waddr       = src_slot_q;
    wentry      = '{mac: hdr_q.src_mac, port: hdr_q.in_port};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (pend_q) begin
      if (rentry.mac == hdr_q.src_mac) begin
        src_hit_d  = 1'b1;
        src_slot_d = pend_idx_q;
      end
      if (rentry.mac == hdr_q.dst_mac) begin
        dst_hit_d  = 1'b1;
        dst_port_d = rentry.port;
      end
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d   = StScan;
          cnt_d     = '0;
          src_hit_d = 1'b0;
          dst_hit_d = 1'b0;
        end
      end
      StScan: begin
        // the last read's compare is folded in above on the way out
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (finish) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
          if (src_uni) begin
            if (src_hit_q) begin
              we = 1'b1;
            end else if (has_room) begin
              we      = 1'b1;
              waddr   = count_q[mlft_pkg::IdxW-1:0];
              count_d = count_q + 1'b1;
            end
          end
          if (dst_grp) begin
            out_word_d = '{flood: 1'b1, egress_port: '0};
          end else if (learned && (hdr_q.dst_mac == hdr_q.src_mac)) begin
            out_word_d = '{flood: 1'b0, egress_port: hdr_q.in_port};
          end else if (dst_hit_q) begin
            out_word_d = '{flood: 1'b0, egress_port: dst_port_q};
          end else begin
            out_word_d = '{flood: 1'b1, egress_port: '0};
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hdr_q <= in_word_i;
    end
    pend_idx_q <= cnt_q[mlft_pkg::IdxW-1:0];
    src_hit_q  <= src_hit_d;
    src_slot_q <= src_slot_d;
    dst_hit_q  <= dst_hit_d;
    dst_port_q <= dst_port_d;
    out_word_q <= out_word_d;
  end

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mlft_pkg::CntW'(mlft_pkg::Entries))
    else $error("fill count above table size");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1))
    else $error("fill count moved by more than one");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StScan))
    else $error("accepted header did not start a scan");

  a_pend_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == StScan))
    else $error("RAM read returned outside a scan");
`endif

endmodule
`default_nettype wire
